// ----- design/slrg_pkg.sv -----
// constants, state type and modular subtract for the subtractive lagged generator
package slrg_pkg;

	localparam int unsigned VALUE_W = 30;
	localparam int unsigned SEED_W  = 28;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned LEN     = 55;
	localparam int unsigned STRIDE  = 21;
	localparam int unsigned LAG_OFS = 31;
	localparam int unsigned PASSES  = 4;

	localparam logic [VALUE_W-1:0] MODULUS = VALUE_W'(1000000000);
	localparam logic [SEED_W-1:0]  GOLD    = SEED_W'(161803398);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_DRAW_RD,
		ST_DRAW_WR
	} slrg_state_t;

	// a - b modulo 10^9, both operands already below 10^9
	function automatic logic [VALUE_W-1:0] mod_sub(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] d;
		begin
			d = {1'b0, a} - {1'b0, b};
			if (d[VALUE_W]) begin
				d = d + {1'b0, MODULUS};
			end
			mod_sub = d[VALUE_W-1:0];
		end
	endfunction

endpackage

// ----- design/subtractive_lagged_random_generator_top.sv -----
// subtractive lagged random generator: 55-word table in a memory, sequencer and draw path
// a plain draw reads its table pair in ST_DRAW_RD, then writes back and registers the result
// in ST_DRAW_WR, which waits for a free output; requests are taken only in idle
// a fresh start fills the table, then mixes it (4 passes x 55 read/write pairs)
// reset zeroes the seed and seeded flag, presets the indices; table rebuilt on first request
// the first request after reset always performs a fresh start
module subtractive_lagged_random_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [27:0] cfg_data,       // seed
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // [29:0] value, [31:30] zero
);
	import slrg_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEN - 1);

	// table memory and its two read ports
	logic [VALUE_W-1:0] mem [LEN];
	logic [VALUE_W-1:0] rd_a_q, rd_b_q;
	logic [IDX_W-1:0]   rd_a_addr, rd_b_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;

	slrg_state_t state_q, state_d;

	logic [SEED_W-1:0]  seed_q;
	logic               seeded_q;
	logic [IDX_W-1:0]   first_q, second_q;
	logic [VALUE_W-1:0] cur_q, nxt_q;
	logic [IDX_W-1:0]   slot_q, cnt_q;
	logic [IDX_W-1:0]   mix_a_q, mix_b_q;
	logic [1:0]         pass_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_data_q;

	logic               in_beat, out_free, fresh;
	logic [SEED_W-1:0]  seed_sat;
	logic [VALUE_W-1:0] start_val, diff;
	logic [IDX_W-1:0]   first_nx, second_nx;
	logic [IDX_W:0]     slot_sum;
	logic [IDX_W-1:0]   slot_nx, mix_b_nx;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign fresh         = s_axis_tdata[0] || !seeded_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_data_q};

	// start value from the saturated seed
	assign seed_sat  = (seed_q > GOLD) ? GOLD : seed_q;
	assign start_val = VALUE_W'(GOLD - seed_sat);

	// index stepping with wrap
	assign first_nx  = (first_q >= IDX_W'(LEN)) ? IDX_W'(1) : first_q + IDX_W'(1);
	assign second_nx = (second_q >= IDX_W'(LEN)) ? IDX_W'(1) : second_q + IDX_W'(1);
	assign slot_sum  = {1'b0, slot_q} + (IDX_W+1)'(STRIDE);
	assign slot_nx   = (slot_sum >= (IDX_W+1)'(LEN)) ? IDX_W'(slot_sum - (IDX_W+1)'(LEN))
		: slot_sum[IDX_W-1:0];
	assign mix_b_nx  = (mix_b_q == LAST_IDX) ? '0 : mix_b_q + IDX_W'(1);

	assign diff = mod_sub(rd_a_q, rd_b_q);

	// read addresses: draw pair (held while the result waits) or mixing pair
	always_comb begin
		if (state_q == ST_DRAW_RD) begin
			rd_a_addr = first_nx - IDX_W'(1);
			rd_b_addr = second_nx - IDX_W'(1);
		end else if (state_q == ST_DRAW_WR) begin
			rd_a_addr = first_q - IDX_W'(1);
			rd_b_addr = second_q - IDX_W'(1);
		end else begin
			rd_a_addr = mix_a_q;
			rd_b_addr = mix_b_q;
		end
	end

	// next state and write port
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = diff;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (fresh) begin
						wr_en   = 1'b1;
						wr_addr = LAST_IDX;
						wr_data = start_val;
						state_d = ST_FILL;
					end else begin
						state_d = ST_DRAW_RD;
					end
				end
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = slot_q - IDX_W'(1);
				wr_data = nxt_q;
				if (cnt_q == LAST_IDX - IDX_W'(1)) begin
					state_d = ST_MIX_RD;
				end
			end
			ST_MIX_RD: begin
				state_d = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				wr_en   = 1'b1;
				wr_addr = mix_a_q;
				if (mix_a_q == LAST_IDX && pass_q == 2'(PASSES - 1)) begin
					state_d = ST_DRAW_RD;
				end else begin
					state_d = ST_MIX_RD;
				end
			end
			ST_DRAW_RD: begin
				state_d = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				if (out_free) begin
					wr_en   = 1'b1;
					wr_addr = first_q - IDX_W'(1);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= mem[rd_a_addr];
	end

	always_ff @(posedge clk) begin
		rd_b_q <= mem[rd_b_addr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// indices, seeded flag and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= '0;
			second_q    <= IDX_W'(LAG_OFS);
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_MIX_WR && state_d == ST_DRAW_RD) begin
				first_q  <= '0;
				second_q <= IDX_W'(LAG_OFS);
				seeded_q <= 1'b1;
			end
			if (state_q == ST_DRAW_RD) begin
				first_q  <= first_nx;
				second_q <= second_nx;
			end
			if (state_q == ST_DRAW_WR && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// fill and mixing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			nxt_q   <= '0;
			slot_q  <= '0;
			cnt_q   <= '0;
			mix_a_q <= '0;
			mix_b_q <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cur_q   <= start_val;
					nxt_q   <= VALUE_W'(1);
					slot_q  <= IDX_W'(STRIDE);
					cnt_q   <= '0;
					mix_a_q <= '0;
					mix_b_q <= IDX_W'(LAG_OFS);
					pass_q  <= '0;
				end
				ST_FILL: begin
					nxt_q  <= mod_sub(cur_q, nxt_q);
					cur_q  <= nxt_q;
					slot_q <= slot_nx;
					cnt_q  <= cnt_q + IDX_W'(1);
				end
				ST_MIX_WR: begin
					mix_b_q <= mix_b_nx;
					if (mix_a_q == LAST_IDX) begin
						mix_a_q <= '0;
						pass_q  <= pass_q + 2'd1;
					end else begin
						mix_a_q <= mix_a_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW_WR && out_free) begin
			out_data_q <= diff;
		end
	end

endmodule
